// ===== rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the sorted set table: op codes, field
// widths, sequencer states and the result record.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int SLOTS_DEF      = 32;
    localparam int VALUE_BITS_DEF = 16;

    localparam int OP_W    = 2;
    localparam int VALUE_W = 16;
    localparam int COUNT_W = 5;

    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CMP,
        ST_PROBE,
        ST_INS,
        ST_INS_WR,
        ST_REM,
        ST_REM_WR,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] count;
    } sst_result_t;

    typedef struct packed {
        logic idle;
        logic done;
    } sst_status_t;

endpackage

// ===== rtl/sorted_set_table.sv =====
// ----------------------------------------------------------------------------
// sorted_set_table
// Set of distinct values kept in ascending order; find, insert and remove,
// each item answered with an ok flag and the count held afterwards.
// A find runs a binary search over the entries and probes the slot it lands
// on; a successful insert or remove then shifts the entries one by one.
// One item at a time: the search loop and the shift loop over the store
// keep the input stalled until the item is done.
// Reset empties the set at once; the store is not cleared.
// ----------------------------------------------------------------------------
module sorted_set_table #(
    parameter int SLOTS      = sst_pkg::SLOTS_DEF,
    parameter int VALUE_BITS = sst_pkg::VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // value[15:0]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // ok[0], count[5:1], zero[7:6]
);

    import sst_pkg::*;

    localparam int CNT_W  = $clog2(SLOTS);
    localparam int ADDR_W = (SLOTS > 2) ? $clog2(SLOTS - 1) : 1;

    sst_status_t           status;
    sst_result_t           result;
    sst_result_t           out_reg;
    logic                  m_valid_reg;
    logic                  out_free;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = status.idle;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_reg.count, out_reg.ok};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (status.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (status.done) begin
            out_reg <= result;
        end
    end

    sst_engine #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W),
        .ADDR_W     (ADDR_W)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_tvalid && s_tready),
        .op        (s_tuser),
        .value     (s_tdata),
        .out_free  (out_free),
        .status    (status),
        .result    (result),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    sst_ram #(
        .WIDTH  (VALUE_BITS),
        .DEPTH  (SLOTS - 1),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== rtl/sst_ram.sv =====
// ----------------------------------------------------------------------------
// sst_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module sst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 31,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sst_engine.sv =====
// ----------------------------------------------------------------------------
// sst_engine
// Sequencer of the sorted set table: binary search over the store, then an
// entry-by-entry shift for insert and remove.
// ----------------------------------------------------------------------------
module sst_engine #(
    parameter int SLOTS      = 32,
    parameter int VALUE_BITS = 16,
    parameter int CNT_W      = $clog2(SLOTS),
    parameter int ADDR_W     = (SLOTS > 2) ? $clog2(SLOTS - 1) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [sst_pkg::OP_W-1:0]    op,
    input  logic [sst_pkg::VALUE_W-1:0] value,
    input  logic                        out_free,
    output sst_pkg::sst_status_t        status,
    output sst_pkg::sst_result_t        result,
    output logic                        ram_we,
    output logic [ADDR_W-1:0]           ram_waddr,
    output logic [VALUE_BITS-1:0]       ram_wdata,
    output logic [ADDR_W-1:0]           ram_raddr,
    input  logic [VALUE_BITS-1:0]       ram_rdata
);

    import sst_pkg::*;

    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(SLOTS - 1);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    logic                  ok_reg, ok_next;

    logic [31:0]           value_ext;
    logic [31:0]           count_ext;
    logic [CNT_W-1:0]      mid;
    logic [CNT_W:0]        k_plus;
    logic                  found;

    assign value_ext = 32'(value);
    assign count_ext = 32'(count_reg);
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign k_plus    = {1'b0, k_reg} + 1'b1;
    assign found     = (lo_reg < count_reg) && (ram_rdata == v_reg);

    assign status.idle   = (state_reg == ST_IDLE);
    assign status.done   = (state_reg == ST_FIN) && out_free;
    assign result.ok     = ok_reg;
    assign result.count  = count_ext[COUNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        k_reg  <= k_next;
        op_reg <= op_next;
        v_reg  <= v_next;
        ok_reg <= ok_next;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        k_next     = k_reg;
        op_next    = op_reg;
        v_next     = v_reg;
        ok_next    = ok_reg;
        ram_we     = 1'b0;
        ram_waddr  = k_reg[ADDR_W-1:0];
        ram_wdata  = ram_rdata;
        ram_raddr  = lo_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    op_next    = op;
                    v_next     = value_ext[VALUE_BITS-1:0];
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (lo_reg < hi_reg) begin
                    ram_raddr  = mid[ADDR_W-1:0];
                    state_next = ST_CMP;
                end else begin
                    ram_raddr  = lo_reg[ADDR_W-1:0];
                    state_next = ST_PROBE;
                end
            end
            ST_CMP: begin
                if (ram_rdata < v_reg) begin
                    lo_next = mid + 1'b1;
                end else begin
                    hi_next = mid;
                end
                state_next = ST_SEARCH;
            end
            ST_PROBE: begin
                ok_next    = 1'b0;
                state_next = ST_FIN;
                unique case (op_reg)
                    OP_FIND: begin
                        ok_next = found;
                    end
                    OP_INSERT: begin
                        if (!found && (count_reg < CAPACITY)) begin
                            k_next     = count_reg;
                            state_next = ST_INS;
                        end
                    end
                    OP_REMOVE: begin
                        if (found) begin
                            k_next     = lo_reg;
                            state_next = ST_REM;
                        end
                    end
                    default: begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            ST_INS: begin
                if (k_reg > lo_reg) begin
                    ram_raddr  = k_reg[ADDR_W-1:0] - 1'b1;
                    state_next = ST_INS_WR;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = lo_reg[ADDR_W-1:0];
                    ram_wdata  = v_reg;
                    count_next = count_reg + 1'b1;
                    ok_next    = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_INS_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = k_reg[ADDR_W-1:0];
                k_next     = k_reg - 1'b1;
                state_next = ST_INS;
            end
            ST_REM: begin
                if (k_plus < {1'b0, count_reg}) begin
                    ram_raddr  = k_plus[ADDR_W-1:0];
                    state_next = ST_REM_WR;
                end else begin
                    count_next = count_reg - 1'b1;
                    ok_next    = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_REM_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = k_reg[ADDR_W-1:0];
                k_next     = k_plus[CNT_W-1:0];
                state_next = ST_REM;
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
